// ----- rtl/core/pgf_pkg.sv -----
`default_nettype none
package pgf_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV    = 2'd0,
    CFG_MIN_DSQ = 2'd1,
    CFG_MAX_DSQ = 2'd2
  } cfg_idx_e;

endpackage
`default_nettype wire

// ----- rtl/core/pgf_if.sv -----
`default_nettype none
// Body pair request channel
interface pgf_req_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] a_pos_x;
  logic signed [WORD_BITS-1:0] a_pos_y;
  logic signed [WORD_BITS-1:0] b_pos_x;
  logic signed [WORD_BITS-1:0] b_pos_y;
  logic        [WORD_BITS-1:0] mass_a;
  logic        [WORD_BITS-1:0] mass_b;

  modport source (output valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, mass_a, mass_b,
                  input ready);
  modport sink   (input valid, a_pos_x, a_pos_y, b_pos_x, b_pos_y, mass_a, mass_b,
                  output ready);
endinterface

// Force result channel
interface pgf_rsp_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] force_x;
  logic signed [WORD_BITS-1:0] force_y;
  logic                        saturated;

  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink   (input valid, force_x, force_y, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/pgf_div_cell.sv -----
`default_nettype none
// One restoring division step: shift in a numerator bit, subtract when it fits,
// shift the quotient bit into the freed low end of the numerator word.
module pgf_div_cell #(
  parameter int DW     = 32,
  parameter int NW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DW-1:0]     rem_i,
  input  logic [NW-1:0]     nq_i,
  input  logic [DW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [DW-1:0]     rem_o,
  output logic [NW-1:0]     nq_o,
  output logic [DW-1:0]     den_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [NW-1:0] nq_d;

  always_comb begin
    trial = {rem_i, nq_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_d  = {nq_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      nq_o   <= nq_d;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pgf_sqrt_cell.sv -----
`default_nettype none
// One digit-by-digit square root step: take two radicand bits, settle one root bit.
module pgf_sqrt_cell #(
  parameter int RW = 33,
  parameter int NW = 66
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW:0]   rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [NW-1:0] n_i,
  output logic [RW:0]   rem_o,
  output logic [RW-1:0] root_o,
  output logic [NW-1:0] n_o
);

  logic [RW+2:0] acc;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  always_comb begin
    acc   = {rem_i, n_i[NW-1:NW-2]};
    trial = {1'b0, root_i, 2'b01};
    diff  = acc - trial;
    ge    = (acc >= trial);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[RW:0] : acc[RW:0];
      root_o <= {root_i[RW-2:0], ge};
      n_o    <= {n_i[NW-3:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pairwise_gravity_force_2d.sv -----
`default_nettype none
// Channel  Dir  Carries                                  Accepted when
// req_i    in   a_pos_x/y, b_pos_x/y, mass_a, mass_b     req_i.valid && req_i.ready
// rsp_o    out  force_x, force_y, saturated              rsp_o.valid && rsp_o.ready
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i         cfg_we_i
//
// One request per cycle while no result is held at rsp_o with ready low.
// The pipeline runs two chains of division cells in series (magnitude,
// then the components), with the square root chain running beside the first.
// Reset clears the stage valid bits and loads the register defaults.
// A result held at rsp_o with ready low freezes every stage and drops req_i.ready.
module pairwise_gravity_force_2d
  import pgf_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pgf_req_if.sink              req_i,
  pgf_rsp_if.source            rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_wdata_i
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int L      = 2 * W + 6;      // stage count up to the output register
  localparam int MSIDE  = 2 * W + 7;      // side data through the magnitude divider
  localparam int CSIDE  = 5;              // side data through the x component divider

  localparam logic [W-1:0] ONE_FX = W'(1) << F;
  localparam logic [W-1:0] SMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN   = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [W-1:0] grav_q, min_dsq_q, max_dsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q    <= ONE_FX;
      min_dsq_q <= ONE_FX;
      max_dsq_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAV:    grav_q    <= cfg_wdata_i;
        CFG_MIN_DSQ: min_dsq_q <= cfg_wdata_i;
        CFG_MAX_DSQ: max_dsq_q <= cfg_wdata_i;
        default: ;  // unmapped index, drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole row advances together unless the result is stuck
  // ---------------------------------------------------------------------------
  logic         adv;
  logic [L:1]   vld_q;

  assign adv         = !vld_q[L] || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-1:1], req_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: displacement, magnitudes, G*mA
  // ---------------------------------------------------------------------------
  logic [W:0]     dx_d, dy_d, ux_d, uy_d;
  logic [W:0]     s1_ux_q, s1_uy_q;
  logic           s1_sx_q, s1_sy_q;
  logic [2*W-1:0] s1_gm_q;
  logic [W-1:0]   s1_mb_q;

  always_comb begin
    dx_d = {req_i.b_pos_x[W-1], req_i.b_pos_x} - {req_i.a_pos_x[W-1], req_i.a_pos_x};
    dy_d = {req_i.b_pos_y[W-1], req_i.b_pos_y} - {req_i.a_pos_y[W-1], req_i.a_pos_y};
    ux_d = dx_d[W] ? (~dx_d + 1'b1) : dx_d;
    uy_d = dy_d[W] ? (~dy_d + 1'b1) : dy_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ux_q <= ux_d;
      s1_uy_q <= uy_d;
      s1_sx_q <= dx_d[W];
      s1_sy_q <= dy_d[W];
      s1_gm_q <= (2*W)'(grav_q) * (2*W)'(req_i.mass_a);
      s1_mb_q <= req_i.mass_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the displacement, saturate p1
  // ---------------------------------------------------------------------------
  logic [2*W-1:0] gm_sh;
  logic           p1_sat;
  logic [2*W+1:0] s2_sqx_q, s2_sqy_q;
  logic [W-1:0]   s2_p1_q, s2_mb_q;
  logic [W:0]     s2_ux_q, s2_uy_q;
  logic           s2_sx_q, s2_sy_q, s2_flag_q;

  always_comb begin
    gm_sh  = s1_gm_q >> F;
    p1_sat = |gm_sh[2*W-1:W];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sqx_q  <= (2*W+2)'(s1_ux_q) * (2*W+2)'(s1_ux_q);
      s2_sqy_q  <= (2*W+2)'(s1_uy_q) * (2*W+2)'(s1_uy_q);
      s2_p1_q   <= p1_sat ? '1 : gm_sh[W-1:0];
      s2_flag_q <= p1_sat;
      s2_mb_q   <= s1_mb_q;
      s2_ux_q   <= s1_ux_q;
      s2_uy_q   <= s1_uy_q;
      s2_sx_q   <= s1_sx_q;
      s2_sy_q   <= s1_sy_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared length, p1*mB
  // ---------------------------------------------------------------------------
  logic [2*W+1:0] s3_s2_q;
  logic [2*W-1:0] s3_pm_q;
  logic [W:0]     s3_ux_q, s3_uy_q;
  logic           s3_sx_q, s3_sy_q, s3_flag_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_s2_q   <= s2_sqx_q + s2_sqy_q;
      s3_pm_q   <= (2*W)'(s2_p1_q) * (2*W)'(s2_mb_q);
      s3_flag_q <= s2_flag_q;
      s3_ux_q   <= s2_ux_q;
      s3_uy_q   <= s2_uy_q;
      s3_sx_q   <= s2_sx_q;
      s3_sy_q   <= s2_sy_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: distance squared to Q format, saturate and clamp; saturate p2
  // ---------------------------------------------------------------------------
  logic [2*W+1:0] s2_sh;
  logic           dsq_sat;
  logic [W-1:0]   dsq_raw, dsq_hi, dsq_d;
  logic [2*W-1:0] pm_sh;
  logic           p2_sat;
  logic [W-1:0]   s4_dsq_q, s4_p2_q;
  logic [W:0]     s4_ux_q, s4_uy_q;
  logic           s4_sx_q, s4_sy_q, s4_flag_q;

  always_comb begin
    s2_sh   = s3_s2_q >> F;
    dsq_sat = |s2_sh[2*W+1:W];
    dsq_raw = dsq_sat ? '1 : s2_sh[W-1:0];
    // upper clamp first, so a minimum above the maximum wins
    dsq_hi  = (dsq_raw > max_dsq_q) ? max_dsq_q : dsq_raw;
    dsq_d   = (dsq_hi < min_dsq_q) ? min_dsq_q : dsq_hi;
    pm_sh   = s3_pm_q >> F;
    p2_sat  = |pm_sh[2*W-1:W];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_dsq_q  <= dsq_d;
      s4_p2_q   <= p2_sat ? '1 : pm_sh[W-1:0];
      s4_flag_q <= s3_flag_q | dsq_sat | p2_sat;
      s4_ux_q   <= s3_ux_q;
      s4_uy_q   <= s3_uy_q;
      s4_sx_q   <= s3_sx_q;
      s4_sy_q   <= s3_sy_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Magnitude divider: (p2 << F) / dsq, one quotient bit per cell.
  // Overflow of the word is known up front from the high numerator half.
  // ---------------------------------------------------------------------------
  logic [W+F-1:0] mnum;
  logic [W+F-1:0] mnum_hi;
  logic           dsq_zero, mag_max, mag_zero;
  logic [W-1:0]   m_rem [0:W];
  logic [W-1:0]   m_nq  [0:W];
  logic [W-1:0]   m_den [0:W];
  logic [MSIDE-1:0] m_side [0:W];

  always_comb begin
    mnum     = {s4_p2_q, {F{1'b0}}};
    mnum_hi  = mnum >> W;
    dsq_zero = (s4_dsq_q == '0);
    mag_zero = dsq_zero && (s4_p2_q == '0);
    mag_max  = dsq_zero ? (s4_p2_q != '0) : (mnum_hi >= (W+F)'(s4_dsq_q));
    m_rem[0] = mnum_hi[W-1:0];
    m_nq[0]  = mnum[W-1:0];
    m_den[0] = s4_dsq_q;
    m_side[0] = {s4_flag_q | mag_max, mag_max, mag_zero, s4_sx_q, s4_sy_q,
                 s4_ux_q, s4_uy_q};
  end

  for (genvar k = 0; k < W; k++) begin : g_mdiv
    pgf_div_cell #(.DW(W), .NW(W), .SIDE_W(MSIDE)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (m_rem[k]),
      .nq_i   (m_nq[k]),
      .den_i  (m_den[k]),
      .side_i (m_side[k]),
      .rem_o  (m_rem[k+1]),
      .nq_o   (m_nq[k+1]),
      .den_o  (m_den[k+1]),
      .side_o (m_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Length: floor(sqrt(s2)), fed from stage 3 so it lands beside the magnitude
  // ---------------------------------------------------------------------------
  logic [W+1:0]   r_rem  [0:W+1];
  logic [W:0]     r_root [0:W+1];
  logic [2*W+1:0] r_n    [0:W+1];

  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_n[0]    = s3_s2_q;

  for (genvar k = 0; k < W + 1; k++) begin : g_sqrt
    pgf_sqrt_cell #(.RW(W+1), .NW(2*W+2)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (r_rem[k]),
      .root_i (r_root[k]),
      .n_i    (r_n[k]),
      .rem_o  (r_rem[k+1]),
      .root_o (r_root[k+1]),
      .n_o    (r_n[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Product stage: mag * |d|
  // ---------------------------------------------------------------------------
  logic           me_flag, me_max, me_zero, me_sx, me_sy;
  logic [W:0]     me_ux, me_uy;
  logic [W-1:0]   mag;
  logic [2*W:0]   p_px_q, p_py_q;
  logic [W:0]     p_len_q;
  logic           p_flag_q, p_sx_q, p_sy_q;

  always_comb begin
    {me_flag, me_max, me_zero, me_sx, me_sy, me_ux, me_uy} = m_side[W];
    mag = me_max ? '1 : (me_zero ? '0 : m_nq[W]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_px_q   <= (2*W+1)'(mag) * (2*W+1)'(me_ux);
      p_py_q   <= (2*W+1)'(mag) * (2*W+1)'(me_uy);
      p_len_q  <= r_root[W+1];
      p_flag_q <= me_flag;
      p_sx_q   <= me_sx;
      p_sy_q   <= me_sy;
    end
  end

  // ---------------------------------------------------------------------------
  // Component dividers: mag*|d| / len, x and y side by side
  // ---------------------------------------------------------------------------
  logic           len_zero, ovf_x, ovf_y;
  logic [W:0]     cx_rem [0:W];
  logic [W-1:0]   cx_nq  [0:W];
  logic [W:0]     cx_den [0:W];
  logic [CSIDE-1:0] cx_side [0:W];
  logic [W:0]     cy_rem [0:W];
  logic [W-1:0]   cy_nq  [0:W];
  logic [W:0]     cy_den [0:W];
  logic [0:0]     cy_side [0:W];

  always_comb begin
    len_zero   = (p_len_q == '0);
    ovf_x      = (p_px_q[2*W:W] >= p_len_q);
    ovf_y      = (p_py_q[2*W:W] >= p_len_q);
    cx_rem[0]  = p_px_q[2*W:W];
    cx_nq[0]   = p_px_q[W-1:0];
    cx_den[0]  = p_len_q;
    cx_side[0] = {p_flag_q, len_zero, p_sx_q, p_sy_q, ovf_x};
    cy_rem[0]  = p_py_q[2*W:W];
    cy_nq[0]   = p_py_q[W-1:0];
    cy_den[0]  = p_len_q;
    cy_side[0] = ovf_y;
  end

  for (genvar k = 0; k < W; k++) begin : g_cdiv
    pgf_div_cell #(.DW(W+1), .NW(W), .SIDE_W(CSIDE)) u_cell_x (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (cx_rem[k]),
      .nq_i   (cx_nq[k]),
      .den_i  (cx_den[k]),
      .side_i (cx_side[k]),
      .rem_o  (cx_rem[k+1]),
      .nq_o   (cx_nq[k+1]),
      .den_o  (cx_den[k+1]),
      .side_o (cx_side[k+1])
    );
    pgf_div_cell #(.DW(W+1), .NW(W), .SIDE_W(1)) u_cell_y (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (cy_rem[k]),
      .nq_i   (cy_nq[k]),
      .den_i  (cy_den[k]),
      .side_i (cy_side[k]),
      .rem_o  (cy_rem[k+1]),
      .nq_o   (cy_nq[k+1]),
      .den_o  (cy_den[k+1]),
      .side_o (cy_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: apply sign and saturate each component to the signed range
  // ---------------------------------------------------------------------------
  function automatic logic [W:0] fit_signed(input logic [W-1:0] q, input logic ovf,
                                            input logic neg);
    logic [W-1:0] v;
    logic         s;
    begin
      if (!neg) begin
        s = ovf || (q > SMAX);
        v = s ? SMAX : q;
      end else begin
        s = ovf || (q > SMIN);
        v = s ? SMIN : (~q + 1'b1);
      end
      return {s, v};
    end
  endfunction

  logic         c_flag, c_lz, c_sx, c_sy, c_ovfx;
  logic [W:0]   fx, fy;
  logic [W-1:0] out_fx_q, out_fy_q;
  logic         out_sat_q;

  always_comb begin
    {c_flag, c_lz, c_sx, c_sy, c_ovfx} = cx_side[W];
    fx = fit_signed(cx_nq[W], c_ovfx, c_sx);
    fy = fit_signed(cy_nq[W], cy_side[W][0], c_sy);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // zero displacement: no direction, no component saturation
      out_fx_q  <= c_lz ? '0 : fx[W-1:0];
      out_fy_q  <= c_lz ? '0 : fy[W-1:0];
      out_sat_q <= c_flag | (!c_lz & (fx[W] | fy[W]));
    end
  end

  assign rsp_o.valid     = vld_q[L];
  assign rsp_o.force_x   = out_fx_q;
  assign rsp_o.force_y   = out_fy_q;
  assign rsp_o.saturated = out_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_blocks_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while the result is stalled");

  a_accept_enters_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> vld_q[1])
    else $error("accepted request missing from the first stage");

  a_result_from_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(vld_q[L-1]))
    else $error("result appeared without a request in the last cell");

endmodule
`default_nettype wire

// ----- tb/sv/tb_pairwise_gravity_force_2d.sv -----
`default_nettype none
module tb_pairwise_gravity_force_2d
  import pgf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WB = 32;
  localparam int FB = 16;
  // Pipeline depth of the top level (2*WORD_BITS+6)
  localparam int PIPE_LAT = 2 * WB + 6;
  localparam int CYCLE_LIMIT = 600000;
  // Index 3 has no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [WB-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [WB-1:0] U_MAX = 32'hFFFF_FFFF;
  localparam logic [WB-1:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [WB-1:0] S_MIN = 32'h8000_0000;

  typedef struct {
    logic signed [WB-1:0] ax, ay, bx, by;
    logic [WB-1:0] ma, mb;
  } body_pair_t;

  typedef struct {
    logic signed [WB-1:0] fx, fy;
    logic sat;
  } force_t;

  // Holds the register copy, predicts each accepted request and checks results
  class force_ledger;
    logic [WB-1:0] g_const = ONE_Q;
    logic [WB-1:0] dsq_floor = ONE_Q;
    logic [WB-1:0] dsq_ceil = U_MAX;
    force_t expected_forces[$];
    int mismatches = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WB-1:0] val);
      case (idx)
        CFG_GRAV: g_const = val;
        CFG_MIN_DSQ: dsq_floor = val;
        CFG_MAX_DSQ: dsq_ceil = val;
        default: ;
      endcase
    endfunction

    static function logic [WB-1:0] clip_u(logic [127:0] v, inout bit flag);
      if (v > {96'b0, U_MAX}) begin
        flag = 1'b1;
        return U_MAX;
      end
      return v[WB-1:0];
    endfunction

    static function logic [63:0] root_floor(logic [127:0] v);
      logic [63:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'b0, c} * {64'b0, c} <= v) r = c;
      end
      return r;
    endfunction

    static function logic [WB-1:0] along_axis(logic signed [WB+1:0] dv, logic [WB-1:0] mag,
                                              logic [63:0] len, inout bit flag);
      logic [WB:0] mv;
      logic [WB-1:0] q;
      mv = dv < 0 ? WB'(0) - dv : dv;
      q = clip_u(({96'b0, mag} * {95'b0, mv}) / {64'b0, len}, flag);
      if (dv >= 0) begin
        if (q > S_MAX) begin
          flag = 1'b1;
          q = S_MAX;
        end
        return q;
      end
      if (q > S_MIN) begin
        flag = 1'b1;
        q = S_MIN;
      end
      return -q;
    endfunction

    function force_t predict_force(body_pair_t p);
      logic signed [WB+1:0] dx, dy;
      logic [WB:0] ux, uy;
      logic [127:0] s2;
      logic [WB-1:0] dsq, p1, p2, mag;
      logic [63:0] len;
      bit flag;
      force_t f;
      flag = 0;
      dx = p.bx - p.ax;
      dy = p.by - p.ay;
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      s2 = {95'b0, ux} * {95'b0, ux} + {95'b0, uy} * {95'b0, uy};
      dsq = clip_u(s2 >> FB, flag);
      if (dsq > dsq_ceil) dsq = dsq_ceil;
      if (dsq < dsq_floor) dsq = dsq_floor;
      p1 = clip_u(({96'b0, g_const} * {96'b0, p.ma}) >> FB, flag);
      p2 = clip_u(({96'b0, p1} * {96'b0, p.mb}) >> FB, flag);
      if (dsq == 0) begin
        // zero clamped distance: magnitude pins high unless p2 is zero
        if (p2 != 0) begin
          flag = 1'b1;
          mag = U_MAX;
        end else begin
          mag = '0;
        end
      end else begin
        mag = clip_u(({96'b0, p2} << FB) / {96'b0, dsq}, flag);
      end
      len = root_floor(s2);
      if (len == 0) begin
        f.fx = '0;
        f.fy = '0;
      end else begin
        f.fx = along_axis(dx, mag, len, flag);
        f.fy = along_axis(dy, mag, len, flag);
      end
      f.sat = flag;
      return f;
    endfunction

    function void note_pair(body_pair_t p);
      expected_forces.push_back(predict_force(p));
    endfunction

    function void check_force(force_t got);
      force_t want;
      if (expected_forces.size() == 0) begin
        $error("force result with no request outstanding: fx=%h fy=%h sat=%b",
               got.fx, got.fy, got.sat);
        mismatches++;
        return;
      end
      want = expected_forces.pop_front();
      if (got.fx !== want.fx) begin
        $error("force_x: expected %h, actual %h", want.fx, got.fx);
        mismatches++;
      end
      if (got.fy !== want.fy) begin
        $error("force_y: expected %h, actual %h", want.fy, got.fy);
        mismatches++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %b, actual %b", want.sat, got.sat);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_forces.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_GRAV;
  logic [WB-1:0] cfg_wdata_i = '0;

  pgf_req_if #(.WORD_BITS(WB)) req_if ();
  pgf_rsp_if #(.WORD_BITS(WB)) rsp_if ();

  pairwise_gravity_force_2d #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  force_ledger ledger = new();

  // Idle percentages for the sender and receiver in the current phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off
  bit hold_req = 1'b0;
  int hold_left = 0;
  int unsigned cycle_count = 0;

  always #2 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.a_pos_x = '0;
    req_if.a_pos_y = '0;
    req_if.b_pos_x = '0;
    req_if.b_pos_y = '0;
    req_if.mass_a = '0;
    req_if.mass_b = '0;
    rsp_if.ready = 1'b0;
  end

  // Receiver: decide ready at the falling edge; a hold-off counts down here
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Sample every accepted result at the rising edge
  always @(posedge clk_i) begin
    force_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.fx = rsp_if.force_x;
      got.fy = rsp_if.force_y;
      got.sat = rsp_if.saturated;
      ledger.check_force(got);
    end
  end

  // Watchdog: abort the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pairwise_gravity_force_2d verification failed");
      $finish;
    end
  end

  // Write one register; called at a falling edge, returns at the next one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WB-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    ledger.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one request; idle first at random, hold valid until accepted
  task automatic send_pair(body_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.a_pos_x = p.ax;
    req_if.a_pos_y = p.ay;
    req_if.b_pos_x = p.bx;
    req_if.b_pos_y = p.by;
    req_if.mass_a = p.ma;
    req_if.mass_b = p.mb;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    ledger.note_pair(p);
    @(negedge clk_i);
  endtask

  task automatic send_coords(logic [WB-1:0] ax, ay, bx, by, ma, mb);
    body_pair_t p;
    p.ax = ax;
    p.ay = ay;
    p.bx = bx;
    p.by = by;
    p.ma = ma;
    p.mb = mb;
    send_pair(p);
  endtask

  // Let the pipe run dry so a register write cannot hit an item in flight
  task automatic drain();
    req_if.valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [WB-1:0] pick_pos();
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2, 3, 4, 5: return WB'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WB-1:0] pick_mass();
    case ($urandom_range(9))
      0: return '0;
      1: return U_MAX;
      2, 3, 4, 5, 6: return $urandom_range(32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic body_pair_t pick_pair();
    body_pair_t p;
    int unsigned shape;
    p.ax = pick_pos();
    p.ay = pick_pos();
    p.ma = pick_mass();
    p.mb = pick_mass();
    shape = $urandom_range(9);
    if (shape == 0) begin
      // coincident bodies
      p.bx = p.ax;
      p.by = p.ay;
    end else if (shape < 4) begin
      // near neighbors, offset of a few units
      p.bx = p.ax + WB'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      p.by = p.ay + WB'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    end else begin
      p.bx = pick_pos();
      p.by = pick_pos();
    end
    return p;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_pair(pick_pair());
  endtask

  task automatic set_regs(logic [WB-1:0] g, mn, mx);
    drain();
    write_reg(CFG_GRAV, g);
    write_reg(CFG_MIN_DSQ, mn);
    write_reg(CFG_MAX_DSQ, mx);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pass at reset defaults, no idling
    send_coords(0, 0, 0, 0, ONE_Q, ONE_Q);                 // coincident bodies
    send_coords(0, 0, ONE_Q, 0, ONE_Q, ONE_Q);             // unit pull along +x
    send_coords(0, 0, 0, -ONE_Q, ONE_Q, ONE_Q);            // unit pull along -y
    send_coords(0, 0, 3 * ONE_Q, 4 * ONE_Q, 2 * ONE_Q, 5 * ONE_Q);
    send_coords(S_MAX, S_MAX, S_MIN, S_MIN, U_MAX, U_MAX); // widest span, heaviest
    send_coords(S_MIN, S_MIN, S_MAX, S_MAX, 0, 0);         // widest span, no mass
    send_coords(S_MIN, S_MAX, S_MAX, S_MIN, ONE_Q, ONE_Q);
    send_coords(0, 0, 1, 0, U_MAX, U_MAX);                 // one-lsb gap: components pin
    send_coords(0, 0, -1, -1, U_MAX, ONE_Q);
    send_coords(5, 5, 5, 5, U_MAX, U_MAX);                 // coincident, saturated chain
    send_coords(0, 0, ONE_Q, ONE_Q, 0, U_MAX);
    send_coords(0, 0, ONE_Q, ONE_Q, U_MAX, 0);
    send_coords(S_MIN, 0, 0, 0, ONE_Q, ONE_Q);
    send_coords(0, S_MAX, 0, 0, ONE_Q, ONE_Q);
    send_coords(32'h0000_8000, 0, 0, 32'h0000_8000, ONE_Q, ONE_Q); // below clamp floor

    // Unmapped index must not disturb any register
    drain();
    write_reg(CFG_UNMAPPED, 32'h1234_5678);
    send_coords(0, 0, 2 * ONE_Q, 0, ONE_Q, ONE_Q);
    run_random(250);

    // Zero clamp range with the largest constant; sender idles heavily
    set_regs(U_MAX, 0, 0);
    send_coords(0, 0, 0, 0, ONE_Q, ONE_Q);                 // zero distance, mass present
    send_coords(0, 0, 0, 0, 0, ONE_Q);                     // zero distance, no mass
    send_coords(0, 0, ONE_Q, 0, ONE_Q, ONE_Q);
    send_idle_pct = 82;
    run_random(150);

    // Minimum above maximum: the minimum wins; receiver stalls heavily
    set_regs(0, U_MAX, 0);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    run_random(60);
    set_regs(ONE_Q, 32'h0010_0000, ONE_Q);
    run_random(80);

    // Random registers, one long receiver hold-off; receiver idles, sender idles in the second run
    set_regs($urandom, $urandom_range(32'h0004_0000), $urandom);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    hold_req = 1'b1;
    send_idle_pct = 0;
    run_random(150);
    send_idle_pct = 34;
    run_random(150);

    // Open clamp range, no idling
    set_regs(ONE_Q, 0, U_MAX);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(300);

    // Random constant with a narrow clamp window, both sides idling
    set_regs($urandom, 1, 32'h0010_0000);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    run_random(280);

    req_if.valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("pairwise_gravity_force_2d verification clean");
    end else begin
      $display("pairwise_gravity_force_2d verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
